// ===== hw/rtl/ble_adv_report_peer_filter_defines.svh =====
// Assertion macros shared by the peer filter RTL.
// Depends on nothing; each user supplies signals named clk and rst_n.
`ifndef BLE_ADV_REPORT_PEER_FILTER_DEFINES_SVH
`define BLE_ADV_REPORT_PEER_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLEPF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLEPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/blepf_pkg.sv =====
// Shared types, constants and helpers of the advertising report peer filter.
// Depends on nothing; every RTL module and interface imports it.
package blepf_pkg;

    localparam int UUID_BYTES     = 16;
    localparam int NAME_MAX_BYTES = 16;
    localparam int CHUNK_IDX_W    = $clog2(UUID_BYTES);
    localparam int NAME_IDX_W     = $clog2(NAME_MAX_BYTES);
    localparam int NAME_LEN_W     = 5;
    localparam int REG_IDX_W      = 3;

    localparam logic [7:0] AD_UUID128_PART  = 8'h06;
    localparam logic [7:0] AD_UUID128_FULL  = 8'h07;
    localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

    localparam logic [REG_IDX_W-1:0] REG_UUID_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_UUID_HIGH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NAME_ANY    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NAME_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NAME_LOW    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NAME_HIGH   = 3'd5;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_UUID,
        KIND_NAME
    } kind_t;

    typedef struct packed {
        logic [63:0]           uuid_low;
        logic [63:0]           uuid_high;
        logic                  name_any;
        logic [NAME_LEN_W-1:0] name_length;
        logic [63:0]           name_low;
        logic [63:0]           name_high;
    } cfg_t;

    typedef struct packed {
        logic matched;
        logic malformed;
    } verdict_t;

    // Byte idx of the 128-bit word {hi, lo}, byte 0 in bits 7:0 of lo.
    function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [3:0] idx);
        logic [127:0] word;
        word = {hi, lo};
        return word[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== hw/rtl/blepf_ifs.sv =====
// Handshake channel interfaces of the peer filter: report bytes, verdicts, config writes.
// Depends on blepf_pkg.
interface blepf_in_if
    import blepf_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface blepf_out_if
    import blepf_pkg::*;
;
    logic valid;
    logic ready;
    logic matched;
    logic malformed;

    modport source (output valid, output matched, output malformed, input ready);
    modport sink   (input valid, input matched, input malformed, output ready);
endinterface

interface blepf_cfg_if
    import blepf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [63:0]          wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/ble_adv_report_peer_filter.sv =====
// BLE advertising report peer filter, top level: input stage, config registers, verdict.
// Depends on blepf_pkg, blepf_ifs, blepf_field_walker and the defines header.
//
// Usage: report bytes enter on din, one item per byte, with last_byte set on the
// final byte of a report. For each report exactly one verdict item leaves on dout:
// matched is set when the report carried the configured 128-bit service UUID and an
// accepted peer name; malformed is set when the report ended inside a structure
// before any match. Bytes other than the last produce no output item.
// Configuration registers are written over cfg (reg_index selects the register,
// wdata carries the value); cfg is always ready, and writes are meant to happen only
// while no report is in flight.
// Timing: a byte is registered in the input register at acceptance and judged from there
// by the walker; a final byte's verdict then waits in the verdict register for dout. One
// byte is taken every cycle unless stalled, a rate set by the single input register.
// If dout stalls with a verdict waiting, the next report's bytes still flow through
// the walker; only a second final byte stalls in the input register, and din.ready
// drops until the pending verdict is taken.
// Reset clears the parse state, empties both stages and loads the register defaults:
// everything zero except name_any, which comes up set.
module ble_adv_report_peer_filter
    import blepf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    blepf_cfg_if.sink   cfg,
    blepf_in_if.sink    din,
    blepf_out_if.source dout
);

`include "ble_adv_report_peer_filter_defines.svh"

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    verdict_t   out_reg;
    verdict_t   verdict;
    logic       advance;
    logic       in_take;

    // Configuration registers. The port never back-pressures.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.uuid_low    <= '0;
            cfg_reg.uuid_high   <= '0;
            cfg_reg.name_any    <= 1'b1;
            cfg_reg.name_length <= '0;
            cfg_reg.name_low    <= '0;
            cfg_reg.name_high   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_UUID_LOW:    cfg_reg.uuid_low    <= cfg.wdata;
                REG_UUID_HIGH:   cfg_reg.uuid_high   <= cfg.wdata;
                REG_NAME_ANY:    cfg_reg.name_any    <= cfg.wdata[0];
                REG_NAME_LENGTH: cfg_reg.name_length <= cfg.wdata[NAME_LEN_W-1:0];
                REG_NAME_LOW:    cfg_reg.name_low    <= cfg.wdata;
                REG_NAME_HIGH:   cfg_reg.name_high   <= cfg.wdata;
                default:
                begin
                end
            endcase
        end
    end

    // The registered byte moves on unless it is a final byte and the verdict slot
    // is still occupied by an untaken result.
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || advance;
    assign in_take   = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            s1_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= din.data_byte;
            s1_last_reg <= din.last_byte;
        end
    end

    blepf_field_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .cfg       (cfg_reg),
        .verdict   (verdict)
    );

    // Verdict register: loaded by a final byte, emptied when the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
        begin
            out_reg <= verdict;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.matched   = out_reg.matched;
    assign dout.malformed = out_reg.malformed;

    // A report cannot be both matched and malformed.
    `BLEPF_ASSERT_SAME(a_verdict_exclusive, out_valid_reg,
        !(out_reg.matched && out_reg.malformed), "verdict both matched and malformed")

    // A final byte that leaves the input stage always yields a waiting verdict.
    `BLEPF_ASSERT_NEXT(a_last_makes_verdict, advance && s1_last_reg,
        out_valid_reg, "final byte produced no verdict")

    // A byte held back in the input stage stays there unchanged.
    `BLEPF_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_last_reg),
        "held input byte was lost or changed")

endmodule

// ===== hw/rtl/blepf_field_walker.sv =====
// Length-type-value walker: holds the per-report parse state and judges each byte.
// Depends on blepf_pkg.
module blepf_field_walker
    import blepf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  cfg_t       cfg,
    output verdict_t   verdict
);

    phase_t     phase_reg, phase_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] remain_reg, remain_next;
    logic [7:0] pos_reg, pos_next;
    logic       chunk_eq_reg, chunk_eq_next;
    logic       name_eq_reg, name_eq_next;
    logic       uuid_seen_reg, uuid_seen_next;
    logic       name_seen_reg, name_seen_next;
    logic       match_reg, match_next;

    logic       field_end;
    logic       uuid_hit;
    logic       name_hit;
    logic [7:0] uuid_ref;
    logic [7:0] name_ref;

    assign uuid_ref = pick_byte(cfg.uuid_low, cfg.uuid_high, pos_reg[CHUNK_IDX_W-1:0]);
    assign name_ref = pick_byte(cfg.name_low, cfg.name_high, pos_reg[NAME_IDX_W-1:0]);
    assign uuid_hit = (data_byte == uuid_ref);
    assign name_hit = (pos_reg < 8'(NAME_MAX_BYTES)) && (data_byte == name_ref);

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        remain_next    = remain_reg;
        pos_next       = pos_reg;
        chunk_eq_next  = chunk_eq_reg;
        name_eq_next   = name_eq_reg;
        uuid_seen_next = uuid_seen_reg;
        name_seen_next = name_seen_reg;
        match_next     = match_reg;
        field_end      = 1'b0;

        case (phase_reg)
            PH_LEN:
            begin
                if (data_byte == 8'd0)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    remain_next = data_byte;
                    phase_next  = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (data_byte inside {AD_UUID128_PART, AD_UUID128_FULL})
                begin
                    kind_next = KIND_UUID;
                end
                else if (data_byte inside {AD_NAME_SHORT, AD_NAME_COMPLETE})
                begin
                    kind_next = KIND_NAME;
                end
                else
                begin
                    kind_next = KIND_OTHER;
                end
                pos_next      = 8'd0;
                chunk_eq_next = 1'b1;
                name_eq_next  = 1'b1;
                remain_next   = remain_reg - 8'd1;
                if (remain_next == 8'd0)
                begin
                    field_end = 1'b1;
                end
                else
                begin
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                case (kind_reg)
                    KIND_UUID:
                    begin
                        // The last byte of a whole chunk decides it; a partial tail never does.
                        if (pos_reg[CHUNK_IDX_W-1:0] == CHUNK_IDX_W'(UUID_BYTES - 1))
                        begin
                            if (chunk_eq_reg && uuid_hit)
                            begin
                                uuid_seen_next = 1'b1;
                            end
                            chunk_eq_next = 1'b1;
                        end
                        else if (!uuid_hit)
                        begin
                            chunk_eq_next = 1'b0;
                        end
                    end
                    KIND_NAME:
                    begin
                        if (!name_hit)
                        begin
                            name_eq_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                pos_next    = pos_reg + 8'd1;
                remain_next = remain_reg - 8'd1;
                field_end   = (remain_next == 8'd0);
            end
            default:
            begin
            end
        endcase

        if (field_end)
        begin
            if (kind_next == KIND_NAME && !cfg.name_any &&
                cfg.name_length <= NAME_LEN_W'(NAME_MAX_BYTES) &&
                pos_next == 8'(cfg.name_length) && name_eq_next)
            begin
                name_seen_next = 1'b1;
            end
            if (uuid_seen_next && (cfg.name_any || name_seen_next))
            begin
                match_next = 1'b1;
            end
            phase_next = match_next ? PH_DONE : PH_LEN;
        end
    end

    assign verdict.matched   = match_next;
    assign verdict.malformed = !match_next && (phase_next == PH_TYPE || phase_next == PH_VALUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            kind_reg      <= KIND_OTHER;
            remain_reg    <= 8'd0;
            pos_reg       <= 8'd0;
            chunk_eq_reg  <= 1'b1;
            name_eq_reg   <= 1'b1;
            uuid_seen_reg <= 1'b0;
            name_seen_reg <= 1'b0;
            match_reg     <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // A report's final byte hands the walker back to its idle state.
                phase_reg     <= PH_LEN;
                kind_reg      <= KIND_OTHER;
                remain_reg    <= 8'd0;
                pos_reg       <= 8'd0;
                chunk_eq_reg  <= 1'b1;
                name_eq_reg   <= 1'b1;
                uuid_seen_reg <= 1'b0;
                name_seen_reg <= 1'b0;
                match_reg     <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                kind_reg      <= kind_next;
                remain_reg    <= remain_next;
                pos_reg       <= pos_next;
                chunk_eq_reg  <= chunk_eq_next;
                name_eq_reg   <= name_eq_next;
                uuid_seen_reg <= uuid_seen_next;
                name_seen_reg <= name_seen_next;
                match_reg     <= match_next;
            end
        end
    end

endmodule
